FILE: src/assert_macros.svh
// Assertion macros shared by the sorter RTL.
// Self-contained; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define OETS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define OETS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/oets_pkg.sv
// Types shared by the odd-even transposition sorter.
// No dependencies; used by oets_cell and the top level.
`default_nettype none

package oets_pkg;

   localparam int VALUE_W = 32;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last_in;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] sorted_value;
      logic                      last_out;
      logic                      dropped;
   } rsp_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_MIN,
      CELL_MAX,
      CELL_SHIFT_OUT
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SORT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic shift_in;
      logic sort;
      logic shift_out;
   } ctrl_type;

endpackage

`default_nettype wire

FILE: src/odd_even_transposition_sorter_core.sv
// Odd-even transposition sorter: a row of MAX_LEN compare-exchange cells.
// Depends on oets_pkg, oets_cell and assert_macros.svh.
// Beats load while the core is idle; a list of N stored values is then sorted
// (one even or odd pair phase per cycle across the cell row) and emitted from cell 0.
// Result beats are registered; busy stays high while the list sorts and emits.
// Reset clears the FSM, count and overflow flag; stored values are left undefined.
`default_nettype none
`include "assert_macros.svh"

module odd_even_transposition_sorter_core #(
   parameter int MAX_LEN = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire oets_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output oets_pkg::rsp_type      rsp_data
);

   localparam int CNT_W = $clog2(MAX_LEN + 1);

   oets_pkg::state_type state_ff, state_in;
   oets_pkg::ctrl_type  ctrl;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    step_ff;
   logic                overflow_ff;
   logic                rsp_strobe_ff;
   oets_pkg::rsp_type   rsp_ff;
   logic                accept;
   logic                room;
   logic                last_step;

   logic signed [oets_pkg::VALUE_W-1:0] cell_value [MAX_LEN];

   assign accept    = start && !busy;
   assign room      = count_ff < CNT_W'(MAX_LEN);
   assign last_step = step_ff == (count_ff - CNT_W'(1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         oets_pkg::ST_LOAD: begin
            if (accept && req_data.last_in) begin
               state_in = oets_pkg::ST_SORT;
            end
         end
         oets_pkg::ST_SORT: begin
            if (last_step) begin
               state_in = oets_pkg::ST_EMIT;
            end
         end
         oets_pkg::ST_EMIT: begin
            if (last_step) begin
               state_in = oets_pkg::ST_LOAD;
            end
         end
         default: state_in = oets_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      busy           = 1'b1;
      ctrl.shift_in  = 1'b0;
      ctrl.sort      = 1'b0;
      ctrl.shift_out = 1'b0;
      unique case (state_ff)
         oets_pkg::ST_LOAD: begin
            busy          = 1'b0;
            ctrl.shift_in = accept && room;
         end
         oets_pkg::ST_SORT: ctrl.sort      = 1'b1;
         oets_pkg::ST_EMIT: ctrl.shift_out = 1'b1;
         default:           busy           = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= oets_pkg::ST_LOAD;
         count_ff      <= '0;
         step_ff       <= '0;
         overflow_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= ctrl.shift_out;
         case (state_ff)
            oets_pkg::ST_LOAD: begin
               step_ff <= '0;
               if (accept) begin
                  if (room) begin
                     count_ff <= count_ff + CNT_W'(1);
                  end else begin
                     overflow_ff <= 1'b1;
                  end
               end
            end
            oets_pkg::ST_SORT: begin
               step_ff <= last_step ? '0 : step_ff + CNT_W'(1);
            end
            oets_pkg::ST_EMIT: begin
               step_ff <= last_step ? '0 : step_ff + CNT_W'(1);
               if (last_step) begin
                  count_ff    <= '0;
                  overflow_ff <= 1'b0;
               end
            end
            default: step_ff <= '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift_out) begin
         rsp_ff.sorted_value <= cell_value[0];
         rsp_ff.last_out     <= last_step;
         rsp_ff.dropped      <= overflow_ff;
      end
   end

   for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
      localparam logic [CNT_W-1:0] IDX      = CNT_W'(i);
      localparam logic [CNT_W-1:0] IDX_NEXT = CNT_W'(i + 1);
      localparam logic             PAR      = 1'(i % 2);
      localparam logic             PAR_PREV = 1'((i + 1) % 2);
      localparam logic             HAS_PREV = (i != 0);

      oets_pkg::cell_op_type               op;
      logic signed [oets_pkg::VALUE_W-1:0] prev_value;
      logic signed [oets_pkg::VALUE_W-1:0] next_value;
      logic                                pair_lo;
      logic                                pair_hi;

      if (i == 0) begin : g_first
         assign prev_value = req_data.value;
      end else begin : g_inner
         assign prev_value = cell_value[i-1];
      end

      if (i == MAX_LEN - 1) begin : g_last
         assign next_value = cell_value[i];
      end else begin : g_body
         assign next_value = cell_value[i+1];
      end

      assign pair_lo = (step_ff[0] == PAR) && (IDX_NEXT < count_ff);
      assign pair_hi = HAS_PREV && (step_ff[0] == PAR_PREV) && (IDX < count_ff);

      always_comb begin
         if (ctrl.shift_in) begin
            op = oets_pkg::CELL_LOAD;
         end else if (ctrl.sort && pair_lo) begin
            op = oets_pkg::CELL_MIN;
         end else if (ctrl.sort && pair_hi) begin
            op = oets_pkg::CELL_MAX;
         end else if (ctrl.shift_out) begin
            op = oets_pkg::CELL_SHIFT_OUT;
         end else begin
            op = oets_pkg::CELL_HOLD;
         end
      end

      oets_cell u_cell (
         .clock      (clock),
         .op         (op),
         .prev_value (prev_value),
         .next_value (next_value),
         .value      (cell_value[i])
      );
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   `OETS_ASSERT_NEXT(a_emit_strobes, clock, reset, state_ff == oets_pkg::ST_EMIT, rsp_strobe, "emit cycle gave no result beat")
   `OETS_ASSERT_NOW(a_count_nonzero, clock, reset, state_ff != oets_pkg::ST_LOAD, count_ff != '0, "sorting or emitting an empty list")
   `OETS_ASSERT_NOW(a_idle_after_last, clock, reset, rsp_strobe && rsp_data.last_out, !busy, "still busy after the final result beat")

endmodule

`default_nettype wire

FILE: src/oets_cell.sv
// One cell of the sorting row: holds one value and trades with its neighbors.
// Depends on oets_pkg.
`default_nettype none

module oets_cell (
   input  wire logic                                   clock,
   input  wire oets_pkg::cell_op_type                  op,
   input  wire logic signed [oets_pkg::VALUE_W-1:0]    prev_value,
   input  wire logic signed [oets_pkg::VALUE_W-1:0]    next_value,
   output logic signed [oets_pkg::VALUE_W-1:0]         value
);

   logic signed [oets_pkg::VALUE_W-1:0] value_ff;
   logic signed [oets_pkg::VALUE_W-1:0] value_in;

   always_comb begin
      unique case (op)
         oets_pkg::CELL_LOAD:      value_in = prev_value;
         oets_pkg::CELL_MIN:       value_in = (value_ff > next_value) ? next_value : value_ff;
         oets_pkg::CELL_MAX:       value_in = (prev_value > value_ff) ? prev_value : value_ff;
         oets_pkg::CELL_SHIFT_OUT: value_in = next_value;
         default:                  value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

FILE: sim/tb_odd_even_transposition_sorter_core.sv
// Self-checking testbench for odd_even_transposition_sorter_core: queued lists are driven
// beat by beat and every sorted burst is checked against an in-bench sorting predictor.
// Depends on oets_pkg and odd_even_transposition_sorter_core.

module tb_odd_even_transposition_sorter_core;

   localparam int LIST_CAP = 32;
   localparam int ITEM_TARGET = 430;
   localparam int DRAIN_CYCLES = 2 * LIST_CAP + 16;
   localparam int CYCLE_LIMIT = 300000;
   localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
   localparam logic signed [31:0] MOST_POS = 32'sh7fff_ffff;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   oets_pkg::req_type req_data = '0;
   logic rsp_strobe;
   oets_pkg::rsp_type rsp_data;

   oets_pkg::req_type pending_beats[$];
   oets_pkg::rsp_type sorted_expect[$];

   logic signed [31:0] held_values[LIST_CAP];
   int held_count = 0;
   logic held_overflow = 1'b0;

   logic beat_taken = 1'b0;
   int gap_left = 0;
   int calm_left = 0;
   int cycle_count = 0;
   int fail_count = 0;
   int beats_sent = 0;
   int lists_sorted = 0;
   int lists_overflowed = 0;
   int lists_full = 0;
   int results_checked = 0;
   int queued_items = 0;

   odd_even_transposition_sorter_core #(
      .MAX_LEN(LIST_CAP)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic signed [31:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 15);
      case (r)
         0: return MOST_NEG;
         1: return MOST_POS;
         2: return 32'sd0;
         3: return -32'sd1;
         4, 5: return int'($urandom_range(0, 15)) - 8;
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_gap();
      int unsigned r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 59) == 0) begin
         calm_left = 40;
      end
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic push_item(input logic signed [31:0] value, input logic last_in);
      oets_pkg::req_type beat;
      beat.value = value;
      beat.last_in = last_in;
      pending_beats = {pending_beats, beat};
      queued_items++;
   endtask

   task automatic queue_list(input int len);
      for (int k = 0; k < len; k++) begin
         push_item(pick_value(), k == len - 1);
      end
   endtask

   // Stores a beat and, on the marked one, sorts the held list and queues its burst.
   task automatic absorb_beat(input oets_pkg::req_type beat);
      oets_pkg::rsp_type want;
      logic signed [31:0] key;
      int j;
      if (held_count < LIST_CAP) begin
         held_values[held_count] = beat.value;
         held_count++;
      end else begin
         held_overflow = 1'b1;
      end
      if (beat.last_in) begin
         for (int i = 1; i < held_count; i++) begin
            key = held_values[i];
            j = i - 1;
            while (j >= 0 && held_values[j] > key) begin
               held_values[j + 1] = held_values[j];
               j--;
            end
            held_values[j + 1] = key;
         end
         for (int i = 0; i < held_count; i++) begin
            want.sorted_value = held_values[i];
            want.last_out = (i == held_count - 1);
            want.dropped = held_overflow;
            sorted_expect = {sorted_expect, want};
         end
         lists_sorted++;
         if (held_overflow) lists_overflowed++;
         else if (held_count == LIST_CAP) lists_full++;
         held_count = 0;
         held_overflow = 1'b0;
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !beat_taken) begin
         start <= 1'b1;
      end else if (gap_left > 0) begin
         start <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_beats.size() > 0) begin
         req_data <= pending_beats.pop_front();
         start <= 1'b1;
         gap_left <= pick_gap();
      end else begin
         start <= 1'b0;
      end
   end

   always @(posedge clock) begin : monitor
      oets_pkg::rsp_type want;
      beat_taken = !reset && start && !busy;
      if (beat_taken) begin
         absorb_beat(req_data);
         beats_sent++;
      end
      if (!reset && rsp_strobe) begin
         if (sorted_expect.size() == 0) begin
            $error("unexpected result beat: sorted_value %0d", rsp_data.sorted_value);
            fail_count++;
         end else begin
            want = sorted_expect.pop_front();
            results_checked++;
            if (rsp_data.sorted_value !== want.sorted_value) begin
               $error("sorted_value: expected %0d, actual %0d",
                      want.sorted_value, rsp_data.sorted_value);
               fail_count++;
            end
            if (rsp_data.last_out !== want.last_out) begin
               $error("last_out: expected %0b, actual %0b", want.last_out, rsp_data.last_out);
               fail_count++;
            end
            if (rsp_data.dropped !== want.dropped) begin
               $error("dropped: expected %0b, actual %0b", want.dropped, rsp_data.dropped);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("odd_even_transposition_sorter_core regression: fail");
         $finish;
      end
   end

   initial begin
      int unsigned r;
      push_item(MOST_NEG, 1'b1);
      push_item(MOST_POS, 1'b1);
      push_item(32'sd5, 1'b0);
      push_item(-32'sd5, 1'b1);
      push_item(MOST_POS, 1'b0);
      push_item(MOST_NEG, 1'b0);
      push_item(32'sd0, 1'b0);
      push_item(-32'sd1, 1'b0);
      push_item(32'sd1, 1'b0);
      push_item(MOST_NEG, 1'b0);
      push_item(MOST_POS, 1'b0);
      push_item(-32'sd1, 1'b1);
      for (int k = 1; k <= 4; k++) push_item(k, k == 4);
      for (int k = 4; k >= 1; k--) push_item(k, k == 1);
      queue_list(LIST_CAP);
      queue_list(LIST_CAP + 1);
      queue_list(LIST_CAP + 6);
      while (queued_items < ITEM_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 55) queue_list($urandom_range(1, 6));
         else if (r < 80) queue_list($urandom_range(7, 20));
         else if (r < 90) queue_list($urandom_range(21, LIST_CAP - 1));
         else if (r < 95) queue_list(LIST_CAP);
         else queue_list($urandom_range(LIST_CAP + 1, LIST_CAP + 8));
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_beats.size() != 0 || start) @(posedge clock);
      while (sorted_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sorted %0d lists from %0d beats: %0d filled the store, %0d overflowed it.",
               lists_sorted, beats_sent, lists_full, lists_overflowed);
      $display("Checked %0d result beats with %0d errors.", results_checked, fail_count);
      if (fail_count == 0) begin
         $display("odd_even_transposition_sorter_core regression: pass");
      end else begin
         $display("odd_even_transposition_sorter_core regression: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+src
src/oets_pkg.sv
src/oets_cell.sv
src/odd_even_transposition_sorter_core.sv
sim/tb_odd_even_transposition_sorter_core.sv
